// ===== hdl/psm_pkg.sv =====
// shared constants, codes, types and range helpers of the p-code stack machine
package psm_pkg;

    // machine sizes
    localparam int STACK_DEPTH   = 1024;
    localparam int PROGRAM_DEPTH = 512;
    localparam int MAX_LEVEL     = 15;
    localparam int WORD_WIDTH    = 32;

    // field and index widths
    localparam int WW     = WORD_WIDTH;
    localparam int ARG_W  = 32;
    localparam int OP_W   = 3;
    localparam int LV_W   = 4;
    localparam int ACT_W  = 2;
    localparam int ERR_W  = 3;
    localparam int LA_W   = 9;
    localparam int SA_W   = $clog2(STACK_DEPTH);
    localparam int PA_W   = $clog2(PROGRAM_DEPTH);
    localparam int PC_W   = PA_W + 1;
    localparam int LC_W   = $clog2(MAX_LEVEL + 1);
    localparam int IX_W   = ((WW > ARG_W) ? WW : ARG_W) + 2;
    localparam int UOP_W  = 4;

    localparam logic signed [IX_W-1:0] STACK_LIM = IX_W'(STACK_DEPTH);
    localparam logic signed [IX_W-1:0] PROG_LIM  = IX_W'(PROGRAM_DEPTH);

    // item actions
    localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STEP    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

    // opcodes
    localparam logic [OP_W-1:0] OP_LIT = 3'd0;
    localparam logic [OP_W-1:0] OP_OPR = 3'd1;
    localparam logic [OP_W-1:0] OP_LOD = 3'd2;
    localparam logic [OP_W-1:0] OP_STO = 3'd3;
    localparam logic [OP_W-1:0] OP_CAL = 3'd4;
    localparam logic [OP_W-1:0] OP_INT = 3'd5;
    localparam logic [OP_W-1:0] OP_JMP = 3'd6;
    localparam logic [OP_W-1:0] OP_JPC = 3'd7;

    // opr subfunctions
    localparam int OPR_RTN = 0;
    localparam int OPR_NEG = 1;
    localparam int OPR_ADD = 2;
    localparam int OPR_SUB = 3;
    localparam int OPR_MUL = 4;
    localparam int OPR_DIV = 5;
    localparam int OPR_ODD = 6;
    localparam int OPR_MOD = 7;
    localparam int OPR_EQL = 8;
    localparam int OPR_NEQ = 9;
    localparam int OPR_LSS = 10;
    localparam int OPR_GEQ = 11;
    localparam int OPR_GTR = 12;
    localparam int OPR_LEQ = 13;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE   = 3'd0;
    localparam logic [ERR_W-1:0] ERR_OP     = 3'd1;
    localparam logic [ERR_W-1:0] ERR_DIV0   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_STACK  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_PROG   = 3'd4;

    // micro-operation codes, also the controller state codes
    localparam logic [UOP_W-1:0] UOP_CLEAR   = 4'd0;
    localparam logic [UOP_W-1:0] UOP_IDLE    = 4'd1;
    localparam logic [UOP_W-1:0] UOP_DECODE  = 4'd2;
    localparam logic [UOP_W-1:0] UOP_EXEC    = 4'd3;
    localparam logic [UOP_W-1:0] UOP_WALK_RD = 4'd4;
    localparam logic [UOP_W-1:0] UOP_WALK_LD = 4'd5;
    localparam logic [UOP_W-1:0] UOP_WALKED  = 4'd6;
    localparam logic [UOP_W-1:0] UOP_RD_A    = 4'd7;
    localparam logic [UOP_W-1:0] UOP_RD_B    = 4'd8;
    localparam logic [UOP_W-1:0] UOP_OPER    = 4'd9;
    localparam logic [UOP_W-1:0] UOP_DIV     = 4'd10;
    localparam logic [UOP_W-1:0] UOP_WR_A    = 4'd11;
    localparam logic [UOP_W-1:0] UOP_WR_B    = 4'd12;
    localparam logic [UOP_W-1:0] UOP_TOP_RD  = 4'd13;
    localparam logic [UOP_W-1:0] UOP_DONE    = 4'd14;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic [LA_W-1:0]         load_address;
        logic [OP_W-1:0]         load_op;
        logic [LV_W-1:0]         load_level;
        logic signed [ARG_W-1:0] load_argument;
    } in_t;

    typedef struct packed {
        logic [OP_W-1:0]         executed_op;
        logic [LV_W-1:0]         executed_level;
        logic signed [ARG_W-1:0] executed_argument;
        logic [SA_W-1:0]         top_index;
        logic [PA_W-1:0]         next_counter;
        logic [SA_W-1:0]         base_index;
        logic signed [WW-1:0]    top_value;
        logic                    halted;
        logic [ERR_W-1:0]        error_code;
    } out_t;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [LV_W-1:0]         level;
        logic signed [ARG_W-1:0] arg;
    } instr_t;

    localparam int PROG_W = $bits(instr_t);

    typedef struct packed {
        logic             take;
        logic [UOP_W-1:0] uop;
    } cmd_t;

    typedef struct packed {
        logic            run;
        logic            fail;
        logic            walk_zero;
        logic            clr_last;
        logic            div_done;
        logic            out_free;
        logic            divop;
        logic [OP_W-1:0] op;
    } stat_t;

    function automatic logic in_stack(input logic signed [IX_W-1:0] v);
        return (v >= 0) && (v < STACK_LIM);
    endfunction

    function automatic logic in_prog(input logic signed [IX_W-1:0] v);
        return (v >= 0) && (v < PROG_LIM);
    endfunction

endpackage

// ===== hdl/psm_ram.sv =====
// generic simple dual-port ram with registered read
module psm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/psm_div.sv =====
// iterative signed divider, one quotient bit per cycle
module psm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [psm_pkg::WW-1:0] dividend,
    input  logic signed [psm_pkg::WW-1:0] divisor,
    output logic                          done,
    output logic signed [psm_pkg::WW-1:0] quotient,
    output logic signed [psm_pkg::WW-1:0] remainder
);
    import psm_pkg::*;

    localparam int CNT_W = $clog2(WW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WW-1:0]    quo_reg, quo_next;
    logic [WW-1:0]    rem_reg, rem_next;
    logic [WW-1:0]    dmag_reg, dmag_next;
    logic             negq_reg, negq_next;
    logic             negr_reg, negr_next;
    logic [WW:0]      shifted;
    logic [WW:0]      diff;

    assign shifted = {rem_reg, quo_reg[WW-1]};
    assign diff    = shifted - {1'b0, dmag_reg};

    // restoring division on magnitudes
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WW);
            quo_next  = dividend[WW-1] ? WW'(-dividend) : WW'(dividend);
            dmag_next = divisor[WW-1] ? WW'(-divisor) : WW'(divisor);
            rem_next  = '0;
            negq_next = dividend[WW-1] ^ divisor[WW-1];
            negr_next = dividend[WW-1];
        end
        else if (busy_reg)
        begin
            if (!diff[WW])
            begin
                rem_next = diff[WW-1:0];
                quo_next = {quo_reg[WW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WW-1:0];
                quo_next = {quo_reg[WW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    // sign correction
    assign done      = done_reg;
    assign quotient  = negq_reg ? $signed(WW'(-quo_reg)) : $signed(quo_reg);
    assign remainder = negr_reg ? $signed(WW'(-rem_reg)) : $signed(rem_reg);

endmodule

// ===== hdl/psm_datapath.sv =====
// datapath: machine registers, program and stack memories, alu and divider
module psm_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  psm_pkg::in_t   in_data,
    input  psm_pkg::cmd_t  cmd,
    output psm_pkg::stat_t st,
    input  logic           out_ready,
    output logic           out_valid,
    output psm_pkg::out_t  out_data
);
    import psm_pkg::*;

    // architectural and working registers
    logic [SA_W-1:0]      top_reg, top_next;
    logic [SA_W-1:0]      base_reg, base_next;
    logic [PC_W-1:0]      counter_reg, counter_next;
    logic                 halted_reg, halted_next;
    logic [ACT_W-1:0]     act_reg, act_next;
    instr_t               ir_reg, ir_next;
    logic signed [WW-1:0] g_reg, g_next;
    logic [LC_W-1:0]      walk_reg, walk_next;
    logic [SA_W-1:0]      addr_reg, addr_next;
    logic signed [WW-1:0] y_reg, y_next;
    logic [ERR_W-1:0]     err_reg, err_next;
    logic                 exec_reg, exec_next;
    logic [SA_W-1:0]      clr_reg, clr_next;
    out_t                 out_reg, out_next;
    logic                 outv_reg, outv_next;

    // memory ports
    logic                 s_we, s_re, p_we, p_re;
    logic [SA_W-1:0]      s_waddr, s_raddr;
    logic [WW-1:0]        s_wdata, s_rdata;
    logic [PA_W-1:0]      p_waddr, p_raddr;
    logic [PROG_W-1:0]    p_wdata, p_rdata;
    instr_t               p_inst;

    // index arithmetic
    logic signed [IX_W-1:0] t_ix, b_ix, a_ix, g_ix, rd_ix, y_ix;
    logic signed [IX_W-1:0] t_p1, t_m1, t_p2, t_p3, t_pa, a_m1, ga, b_p1, b_p2, b_m1;
    logic [PC_W-1:0]        pc_inc;
    logic                   top_zero, counter_ok, fail;
    logic signed [WW-1:0]   x_w, alu;
    logic                   divop, div_start, div_done;
    logic signed [WW-1:0]   quo, rem;

    assign p_inst = instr_t'(p_rdata);
    assign x_w    = $signed(s_rdata);
    assign t_ix   = IX_W'(top_reg);
    assign b_ix   = IX_W'(base_reg);
    assign a_ix   = IX_W'(ir_reg.arg);
    assign g_ix   = IX_W'(g_reg);
    assign rd_ix  = IX_W'(x_w);
    assign y_ix   = IX_W'(y_reg);
    assign t_p1   = t_ix + 1;
    assign t_p2   = t_ix + 2;
    assign t_p3   = t_ix + 3;
    assign t_m1   = t_ix - 1;
    assign t_pa   = t_ix + a_ix;
    assign a_m1   = a_ix - 1;
    assign ga     = g_ix + a_ix;
    assign b_p1   = b_ix + 1;
    assign b_p2   = b_ix + 2;
    assign b_m1   = b_ix - 1;
    assign pc_inc = counter_reg + 1'b1;
    assign top_zero   = (top_reg == '0);
    assign counter_ok = (counter_reg < PC_W'(PROGRAM_DEPTH));
    assign divop  = (ir_reg.op == OP_OPR) && (ir_reg.arg == OPR_DIV || ir_reg.arg == OPR_MOD);

    psm_ram #(.WIDTH(WW), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    psm_ram #(.WIDTH(PROG_W), .DEPTH(PROGRAM_DEPTH)) u_prog (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .re    (p_re),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    psm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (x_w),
        .divisor   (y_reg),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    // binary operations, x below y on the stack
    always_comb
    begin
        unique case (ir_reg.arg)
            OPR_ADD: alu = x_w + y_reg;
            OPR_SUB: alu = x_w - y_reg;
            OPR_MUL: alu = x_w * y_reg;
            OPR_EQL: alu = WW'(x_w == y_reg);
            OPR_NEQ: alu = WW'(x_w != y_reg);
            OPR_LSS: alu = WW'(x_w < y_reg);
            OPR_GEQ: alu = WW'(x_w >= y_reg);
            OPR_GTR: alu = WW'(x_w > y_reg);
            OPR_LEQ: alu = WW'(x_w <= y_reg);
            default: alu = '0;
        endcase
    end

    // micro-operation decode
    always_comb
    begin
        top_next     = top_reg;
        base_next    = base_reg;
        counter_next = counter_reg;
        halted_next  = halted_reg;
        act_next     = act_reg;
        ir_next      = ir_reg;
        g_next       = g_reg;
        walk_next    = walk_reg;
        addr_next    = addr_reg;
        y_next       = y_reg;
        err_next     = err_reg;
        exec_next    = exec_reg;
        clr_next     = clr_reg;
        out_next     = out_reg;
        outv_next    = outv_reg & ~out_ready;
        s_we         = 1'b0;
        s_waddr      = '0;
        s_wdata      = '0;
        s_re         = 1'b0;
        s_raddr      = '0;
        p_we         = 1'b0;
        p_waddr      = in_data.load_address[PA_W-1:0];
        p_wdata      = PROG_W'({in_data.load_op, in_data.load_level, in_data.load_argument});
        p_re         = 1'b0;
        p_raddr      = counter_reg[PA_W-1:0];
        fail         = 1'b0;
        div_start    = 1'b0;
        unique case (cmd.uop)
            UOP_CLEAR:
            begin
                s_we     = 1'b1;
                s_waddr  = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            UOP_IDLE:
            begin
                if (cmd.take)
                begin
                    act_next  = in_data.action;
                    err_next  = ERR_NONE;
                    exec_next = 1'b0;
                    if (in_data.action == ACT_LOAD)
                    begin
                        if (int'(in_data.load_address) < PROGRAM_DEPTH)
                        begin
                            p_we = 1'b1;
                        end
                        else
                        begin
                            err_next = ERR_PROG;
                        end
                    end
                    else if (in_data.action == ACT_RESTART)
                    begin
                        top_next     = '0;
                        base_next    = SA_W'(1);
                        counter_next = '0;
                        halted_next  = 1'b0;
                    end
                    else if (in_data.action == ACT_STEP && !halted_reg)
                    begin
                        if (counter_ok)
                        begin
                            p_re = 1'b1;
                        end
                        else
                        begin
                            err_next = ERR_PROG;
                        end
                    end
                end
            end
            UOP_DECODE:
            begin
                if (act_reg == ACT_STEP && !halted_reg && counter_ok)
                begin
                    ir_next   = p_inst;
                    exec_next = 1'b1;
                    g_next    = WW'(base_reg);
                    walk_next = (int'(p_inst.level) > MAX_LEVEL) ? LC_W'(MAX_LEVEL)
                                                                 : LC_W'(p_inst.level);
                end
            end
            UOP_EXEC:
            begin
                unique case (ir_reg.op)
                    OP_LIT:
                    begin
                        if (in_stack(t_p1))
                        begin
                            s_we         = 1'b1;
                            s_waddr      = t_p1[SA_W-1:0];
                            s_wdata      = WW'(ir_reg.arg);
                            top_next     = t_p1[SA_W-1:0];
                            counter_next = pc_inc;
                        end
                        else
                        begin
                            err_next = ERR_STACK;
                        end
                    end
                    OP_OPR:
                    begin
                        if (ir_reg.arg == OPR_RTN)
                        begin
                            if (!(b_ix >= 1 && in_stack(b_p2)))
                            begin
                                err_next = ERR_STACK;
                                fail     = 1'b1;
                            end
                        end
                        else if (ir_reg.arg == OPR_NEG || ir_reg.arg == OPR_ODD)
                        begin
                            fail = 1'b0;
                        end
                        else if (ir_reg.arg >= OPR_ADD && ir_reg.arg <= OPR_LEQ)
                        begin
                            if (top_zero)
                            begin
                                err_next = ERR_STACK;
                                fail     = 1'b1;
                            end
                        end
                        else
                        begin
                            err_next     = ERR_OP;
                            counter_next = pc_inc;
                            fail         = 1'b1;
                        end
                    end
                    OP_INT:
                    begin
                        if (in_stack(t_pa))
                        begin
                            top_next     = t_pa[SA_W-1:0];
                            counter_next = pc_inc;
                        end
                        else
                        begin
                            err_next = ERR_STACK;
                        end
                    end
                    OP_JMP:
                    begin
                        if (in_prog(a_m1))
                        begin
                            counter_next = a_m1[PC_W-1:0];
                        end
                        else
                        begin
                            err_next = ERR_PROG;
                        end
                    end
                    OP_JPC:
                    begin
                        if (top_zero)
                        begin
                            err_next = ERR_STACK;
                            fail     = 1'b1;
                        end
                    end
                    default:
                    begin
                        fail = 1'b0;
                    end
                endcase
            end
            UOP_WALK_RD:
            begin
                if (walk_reg != '0)
                begin
                    if (in_stack(g_ix))
                    begin
                        s_re    = 1'b1;
                        s_raddr = g_ix[SA_W-1:0];
                    end
                    else
                    begin
                        err_next = ERR_STACK;
                        fail     = 1'b1;
                    end
                end
            end
            UOP_WALK_LD:
            begin
                g_next    = x_w;
                walk_next = walk_reg - 1'b1;
            end
            UOP_WALKED:
            begin
                if (ir_reg.op == OP_LOD)
                begin
                    if (in_stack(ga) && in_stack(t_p1))
                    begin
                        s_re      = 1'b1;
                        s_raddr   = ga[SA_W-1:0];
                        addr_next = ga[SA_W-1:0];
                    end
                    else
                    begin
                        err_next = ERR_STACK;
                        fail     = 1'b1;
                    end
                end
                else if (ir_reg.op == OP_STO)
                begin
                    if (in_stack(ga) && !top_zero)
                    begin
                        s_re      = 1'b1;
                        s_raddr   = top_reg;
                        addr_next = ga[SA_W-1:0];
                    end
                    else
                    begin
                        err_next = ERR_STACK;
                        fail     = 1'b1;
                    end
                end
                else
                begin
                    // call frame: static link first
                    if (!in_stack(t_p3))
                    begin
                        err_next = ERR_STACK;
                        fail     = 1'b1;
                    end
                    else if (!in_prog(a_ix))
                    begin
                        err_next = ERR_PROG;
                        fail     = 1'b1;
                    end
                    else
                    begin
                        s_we    = 1'b1;
                        s_waddr = t_p1[SA_W-1:0];
                        s_wdata = WW'(g_reg);
                    end
                end
            end
            UOP_RD_A:
            begin
                s_re    = 1'b1;
                s_raddr = (ir_reg.op == OP_OPR && ir_reg.arg == OPR_RTN) ? b_p2[SA_W-1:0]
                                                                          : top_reg;
            end
            UOP_RD_B:
            begin
                y_next  = x_w;
                s_re    = 1'b1;
                s_raddr = (ir_reg.op == OP_OPR && ir_reg.arg == OPR_RTN) ? b_p1[SA_W-1:0]
                                                                          : t_m1[SA_W-1:0];
            end
            UOP_OPER:
            begin
                if (ir_reg.op == OP_JPC)
                begin
                    if (y_reg != '0)
                    begin
                        counter_next = pc_inc;
                        top_next     = t_m1[SA_W-1:0];
                    end
                    else if (in_prog(a_m1))
                    begin
                        counter_next = a_m1[PC_W-1:0];
                        top_next     = t_m1[SA_W-1:0];
                    end
                    else
                    begin
                        err_next = ERR_PROG;
                    end
                end
                else if (ir_reg.arg == OPR_RTN)
                begin
                    // y holds the return address, read data the dynamic link
                    if (!in_stack(rd_ix))
                    begin
                        err_next = ERR_STACK;
                    end
                    else if (!in_prog(y_ix))
                    begin
                        err_next = ERR_PROG;
                    end
                    else
                    begin
                        top_next     = b_m1[SA_W-1:0];
                        base_next    = rd_ix[SA_W-1:0];
                        counter_next = y_ix[PC_W-1:0];
                        halted_next  = 1'b1;
                    end
                end
                else if (ir_reg.arg == OPR_NEG)
                begin
                    s_we         = 1'b1;
                    s_waddr      = top_reg;
                    s_wdata      = WW'(-y_reg);
                    counter_next = pc_inc;
                end
                else if (ir_reg.arg == OPR_ODD)
                begin
                    s_we         = 1'b1;
                    s_waddr      = top_reg;
                    s_wdata      = WW'(y_reg[0]);
                    counter_next = pc_inc;
                end
                else if (divop)
                begin
                    div_start = 1'b1;
                end
                else
                begin
                    s_we         = 1'b1;
                    s_waddr      = t_m1[SA_W-1:0];
                    s_wdata      = alu;
                    top_next     = t_m1[SA_W-1:0];
                    counter_next = pc_inc;
                end
            end
            UOP_DIV:
            begin
                if (div_done)
                begin
                    s_we         = 1'b1;
                    s_waddr      = t_m1[SA_W-1:0];
                    top_next     = t_m1[SA_W-1:0];
                    counter_next = pc_inc;
                    if (y_reg == '0)
                    begin
                        s_wdata  = '0;
                        err_next = ERR_DIV0;
                    end
                    else
                    begin
                        s_wdata = (ir_reg.arg == OPR_DIV) ? quo : rem;
                    end
                end
            end
            UOP_WR_A:
            begin
                s_we = 1'b1;
                if (ir_reg.op == OP_LOD)
                begin
                    s_waddr = t_p1[SA_W-1:0];
                    s_wdata = s_rdata;
                end
                else if (ir_reg.op == OP_STO)
                begin
                    s_waddr      = addr_reg;
                    s_wdata      = s_rdata;
                    top_next     = t_m1[SA_W-1:0];
                    counter_next = pc_inc;
                end
                else
                begin
                    s_waddr = t_p2[SA_W-1:0];
                    s_wdata = WW'(base_reg);
                end
            end
            UOP_WR_B:
            begin
                s_we = 1'b1;
                if (ir_reg.op == OP_LOD)
                begin
                    // the loaded cell is left holding minus ten
                    s_waddr      = addr_reg;
                    s_wdata      = WW'(-10);
                    top_next     = t_p1[SA_W-1:0];
                    counter_next = pc_inc;
                end
                else
                begin
                    s_waddr      = t_p3[SA_W-1:0];
                    s_wdata      = WW'(pc_inc);
                    base_next    = t_p1[SA_W-1:0];
                    counter_next = a_ix[PC_W-1:0];
                end
            end
            UOP_TOP_RD:
            begin
                s_re    = 1'b1;
                s_raddr = top_reg;
            end
            UOP_DONE:
            begin
                if (!outv_reg || out_ready)
                begin
                    out_next.executed_op       = exec_reg ? ir_reg.op : '0;
                    out_next.executed_level    = exec_reg ? ir_reg.level : '0;
                    out_next.executed_argument = exec_reg ? ir_reg.arg : '0;
                    out_next.top_index         = top_reg;
                    out_next.next_counter      = counter_reg[PA_W-1:0];
                    out_next.base_index        = base_reg;
                    out_next.top_value         = x_w;
                    out_next.halted            = halted_reg;
                    out_next.error_code        = err_reg;
                    outv_next                  = 1'b1;
                end
            end
            default:
            begin
                fail = 1'b0;
            end
        endcase
    end

    // status back to the controller
    assign st.run       = (act_reg == ACT_STEP) && !halted_reg && counter_ok;
    assign st.fail      = fail;
    assign st.walk_zero = (walk_reg == '0);
    assign st.clr_last  = (clr_reg == SA_W'(STACK_DEPTH - 1));
    assign st.div_done  = div_done;
    assign st.out_free  = !outv_reg || out_ready;
    assign st.divop     = divop;
    assign st.op        = ir_reg.op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg     <= '0;
            base_reg    <= SA_W'(1);
            counter_reg <= '0;
            halted_reg  <= 1'b0;
            clr_reg     <= '0;
            outv_reg    <= 1'b0;
        end
        else
        begin
            top_reg     <= top_next;
            base_reg    <= base_next;
            counter_reg <= counter_next;
            halted_reg  <= halted_next;
            clr_reg     <= clr_next;
            outv_reg    <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        ir_reg   <= ir_next;
        g_reg    <= g_next;
        walk_reg <= walk_next;
        addr_reg <= addr_next;
        y_reg    <= y_next;
        err_reg  <= err_next;
        exec_reg <= exec_next;
        out_reg  <= out_next;
    end

    assign out_valid = outv_reg;
    assign out_data  = out_reg;

endmodule

// ===== hdl/psm_ctrl.sv =====
// controller state machine sequencing the datapath micro-operations
module psm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  psm_pkg::stat_t st,
    output psm_pkg::cmd_t  cmd
);
    import psm_pkg::*;

    localparam logic [UOP_W-1:0] S_CLEAR   = UOP_CLEAR;
    localparam logic [UOP_W-1:0] S_IDLE    = UOP_IDLE;
    localparam logic [UOP_W-1:0] S_DECODE  = UOP_DECODE;
    localparam logic [UOP_W-1:0] S_EXEC    = UOP_EXEC;
    localparam logic [UOP_W-1:0] S_WALK_RD = UOP_WALK_RD;
    localparam logic [UOP_W-1:0] S_WALK_LD = UOP_WALK_LD;
    localparam logic [UOP_W-1:0] S_WALKED  = UOP_WALKED;
    localparam logic [UOP_W-1:0] S_RD_A    = UOP_RD_A;
    localparam logic [UOP_W-1:0] S_RD_B    = UOP_RD_B;
    localparam logic [UOP_W-1:0] S_OPER    = UOP_OPER;
    localparam logic [UOP_W-1:0] S_DIV     = UOP_DIV;
    localparam logic [UOP_W-1:0] S_WR_A    = UOP_WR_A;
    localparam logic [UOP_W-1:0] S_WR_B    = UOP_WR_B;
    localparam logic [UOP_W-1:0] S_TOP_RD  = UOP_TOP_RD;
    localparam logic [UOP_W-1:0] S_DONE    = UOP_DONE;

    logic [UOP_W-1:0] state_reg, state_next;

    // next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:   state_next = st.clr_last ? S_IDLE : S_CLEAR;
            S_IDLE:    state_next = in_valid ? S_DECODE : S_IDLE;
            S_DECODE:  state_next = st.run ? S_EXEC : S_TOP_RD;
            S_EXEC:
            begin
                unique case (st.op)
                    OP_OPR, OP_JPC: state_next = st.fail ? S_TOP_RD : S_RD_A;
                    OP_LOD, OP_STO, OP_CAL: state_next = S_WALK_RD;
                    default: state_next = S_TOP_RD;
                endcase
            end
            S_WALK_RD:
            begin
                priority if (st.walk_zero)
                    state_next = S_WALKED;
                else if (st.fail)
                    state_next = S_TOP_RD;
                else
                    state_next = S_WALK_LD;
            end
            S_WALK_LD: state_next = S_WALK_RD;
            S_WALKED:  state_next = st.fail ? S_TOP_RD : S_WR_A;
            S_RD_A:    state_next = S_RD_B;
            S_RD_B:    state_next = S_OPER;
            S_OPER:    state_next = (st.op == OP_OPR && st.divop) ? S_DIV : S_TOP_RD;
            S_DIV:     state_next = st.div_done ? S_TOP_RD : S_DIV;
            S_WR_A:    state_next = (st.op == OP_STO) ? S_TOP_RD : S_WR_B;
            S_WR_B:    state_next = S_TOP_RD;
            S_TOP_RD:  state_next = S_DONE;
            S_DONE:    state_next = st.out_free ? S_IDLE : S_DONE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign cmd.take = (state_reg == S_IDLE) && in_valid;
    assign cmd.uop  = state_reg;

endmodule

// ===== hdl/pcode_stack_machine_core.sv =====
// top level of the p-code stack machine
//
// One input channel (in_valid/in_ready/in_data) carries items: a load beat
// writes one instruction into program memory, a step beat executes the
// instruction at the program counter, a restart beat resets top, base,
// counter and the halt flag. Every item returns exactly one trace beat on the
// output channel (out_valid/out_ready/out_data).
// One item is worked at a time. A load, restart or idle step goes from accept
// through decode and a top-of-stack read to the output register; LIT, INT and
// JMP add an execute step, OPR and JPC also read two stack cells, LOD/STO/CAL
// walk one static link per level (up to 15) before their writes, and DIV/MOD
// wait on the bit-serial divider.
// After reset the stack memory is swept to zero while in_ready stays low. The
// result sits in an output register; if the receiver stalls, the next item is
// taken but its result waits until the register frees.
module pcode_stack_machine_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  psm_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output psm_pkg::out_t out_data
);
    import psm_pkg::*;

    cmd_t  cmd;
    stat_t st;

    // sequencer
    psm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // registers, memories and arithmetic
    psm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .st        (st),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
